@@ sv/cbd_pkg.sv @@
// shared widths, status codes and register map for the chunked body deframer
package cbd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [CFG_DATA_W-1:0] MAX_BODY_RESET = 32'd1048576;

  typedef enum logic [STATUS_W-1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_BAD        = 2'd2,
    ST_TOO_LARGE  = 2'd3
  } status_e;

  // register index, taken from paddr above the word offset
  typedef enum logic [0:0] {
    REG_MAX_BODY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  localparam logic [BYTE_W-1:0] CHR_CR   = 8'h0d;
  localparam logic [BYTE_W-1:0] CHR_LF   = 8'h0a;
  localparam logic [BYTE_W-1:0] CHR_SEMI = 8'h3b;

endpackage

@@ sv/cbd_if.sv @@
// request channels for body bytes in and per-byte status out
interface cbd_in_if;
  logic                           valid;
  logic                           ready;
  logic [cbd_pkg::BYTE_W-1:0]     body_byte;
  logic                           start_req;

  modport source (output valid, output body_byte, output start_req, input ready);
  modport sink   (input valid, input body_byte, input start_req, output ready);
endinterface

interface cbd_out_if;
  logic                           valid;
  logic                           ready;
  logic [cbd_pkg::STATUS_W-1:0]   status;
  logic                           is_payload;
  logic [cbd_pkg::COUNT_W-1:0]    byte_count;

  modport source (output valid, output status, output is_payload, output byte_count,
                  input ready);
  modport sink   (input valid, input status, input is_payload, input byte_count,
                  output ready);
endinterface

@@ sv/chunked_body_deframer.sv @@
// chunked body deframer: size line, chunk data and trailer checker, one byte per cycle
// an accepted byte's status request appears at the output register in the next cycle
// throughput: one byte per cycle unless stalled; scanner and output update together
// a held output stalls input only when the output is not taken in the same cycle
// reset: scanner state cleared, output empty, max_body_size back to 1048576
// start_req clears the scanner before its own byte is scanned
module chunked_body_deframer #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cbd_in_if.sink                           in_i,
  cbd_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cbd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cbd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    PH_SZ_START,
    PH_SZ_DIGITS,
    PH_SZ_EXT,
    PH_SZ_CR_HEAD,
    PH_SZ_CR_EXT,
    PH_DATA,
    PH_DATA_END1,
    PH_DATA_END2,
    PH_TRL_START,
    PH_TRL_CR0,
    PH_TRL_BODY,
    PH_TRL_CR,
    PH_DONE
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [SIZE_BITS-1:0]            clen_q, clen_d;
  logic [SIZE_BITS-1:0]            dleft_q, dleft_d;
  logic                            linv_q, linv_d;
  logic [cbd_pkg::COUNT_W-1:0]     total_q, total_d;
  cbd_pkg::status_e                fstat_q, fstat_d;
  logic [cbd_pkg::CFG_DATA_W-1:0]  max_q;

  logic                            out_valid_q;
  cbd_pkg::status_e                status_q, status_d;
  logic                            pay_q, pay_d;
  logic [cbd_pkg::COUNT_W-1:0]     count_q;

  logic                            accept;
  logic                            cfg_wr;
  logic [cbd_pkg::BYTE_W-1:0]      b;
  logic                            hex_ok;
  logic [3:0]                      hex_val;
  logic [cbd_pkg::COUNT_W-1:0]     prior_total;
  logic [SIZE_BITS-1:0]            dleft_dec;

  assign b          = in_i.body_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.is_payload = pay_q;
  assign out_o.byte_count = count_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (cbd_pkg::reg_idx_e'(paddr[2]) == cbd_pkg::REG_MAX_BODY);

  always_comb begin
    if (cbd_pkg::reg_idx_e'(paddr[2]) == cbd_pkg::REG_MAX_BODY) begin
      prdata = max_q;
    end else begin
      prdata = '0;
    end
  end

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_ok  = 1'b1;
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_ok  = 1'b1;
      hex_val = 4'(b - 8'h37);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    clen_d   = clen_q;
    dleft_d  = dleft_q;
    linv_d   = linv_q;
    total_d  = total_q;
    fstat_d  = fstat_q;
    status_d = cbd_pkg::ST_INCOMPLETE;
    pay_d    = 1'b0;

    if (in_i.start_req) begin
      phase_d = PH_SZ_START;
      clen_d  = '0;
      dleft_d = '0;
      linv_d  = 1'b0;
      total_d = '0;
      fstat_d = cbd_pkg::ST_INCOMPLETE;
    end

    prior_total = total_d;
    if (total_d != '1) begin
      total_d = total_d + 1'b1;
    end
    dleft_dec = dleft_d - 1'b1;

    if (fstat_d != cbd_pkg::ST_INCOMPLETE) begin
      status_d = fstat_d;
    end else if (prior_total >= max_q) begin
      status_d = cbd_pkg::ST_TOO_LARGE;
    end else begin
      case (phase_d)
        PH_SZ_START, PH_SZ_DIGITS: begin
          if (hex_ok) begin
            if (!linv_d) begin
              if (clen_d[SIZE_BITS-1 -: 4] != 4'd0) begin
                linv_d = 1'b1;
              end else begin
                clen_d = {clen_d[SIZE_BITS-5:0], hex_val};
              end
            end
            phase_d = PH_SZ_DIGITS;
          end else if (b == cbd_pkg::CHR_SEMI) begin
            if (phase_d == PH_SZ_START) linv_d = 1'b1;
            phase_d = PH_SZ_EXT;
          end else if (b == cbd_pkg::CHR_CR) begin
            if (phase_d == PH_SZ_START) begin
              linv_d  = 1'b1;
              phase_d = PH_SZ_CR_EXT;
            end else begin
              phase_d = PH_SZ_CR_HEAD;
            end
          end else begin
            linv_d  = 1'b1;
            phase_d = PH_SZ_EXT;
          end
        end
        PH_SZ_EXT: begin
          if (b == cbd_pkg::CHR_CR) phase_d = PH_SZ_CR_EXT;
        end
        PH_SZ_CR_HEAD, PH_SZ_CR_EXT: begin
          if (b == cbd_pkg::CHR_LF) begin
            if (linv_d) begin
              status_d = cbd_pkg::ST_BAD;
            end else if (clen_d == '0) begin
              phase_d = PH_TRL_START;
            end else begin
              dleft_d = clen_d;
              phase_d = PH_DATA;
            end
          end else begin
            if (phase_d == PH_SZ_CR_HEAD) linv_d = 1'b1;
            phase_d = (b == cbd_pkg::CHR_CR) ? PH_SZ_CR_EXT : PH_SZ_EXT;
          end
        end
        PH_DATA: begin
          pay_d = 1'b1;
          if (dleft_d != '0) begin
            dleft_d = dleft_dec;
          end
          if (dleft_d == '0) phase_d = PH_DATA_END1;
        end
        PH_DATA_END1: begin
          linv_d  = (b != cbd_pkg::CHR_CR);
          phase_d = PH_DATA_END2;
        end
        PH_DATA_END2: begin
          if (linv_d || b != cbd_pkg::CHR_LF) begin
            status_d = cbd_pkg::ST_BAD;
          end else begin
            clen_d  = '0;
            linv_d  = 1'b0;
            phase_d = PH_SZ_START;
          end
        end
        PH_TRL_START: begin
          phase_d = (b == cbd_pkg::CHR_CR) ? PH_TRL_CR0 : PH_TRL_BODY;
        end
        PH_TRL_CR0: begin
          if (b == cbd_pkg::CHR_LF) begin
            status_d = cbd_pkg::ST_COMPLETE;
          end else begin
            phase_d = (b == cbd_pkg::CHR_CR) ? PH_TRL_CR : PH_TRL_BODY;
          end
        end
        PH_TRL_BODY: begin
          if (b == cbd_pkg::CHR_CR) phase_d = PH_TRL_CR;
        end
        PH_TRL_CR: begin
          if (b == cbd_pkg::CHR_LF) begin
            phase_d = PH_TRL_START;
          end else if (b != cbd_pkg::CHR_CR) begin
            phase_d = PH_TRL_BODY;
          end
        end
        default: begin
        end
      endcase
      if (status_d != cbd_pkg::ST_INCOMPLETE) begin
        fstat_d = status_d;
        phase_d = PH_DONE;
      end
    end

    if (status_d != cbd_pkg::ST_INCOMPLETE) pay_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SZ_START;
      clen_q      <= '0;
      dleft_q     <= '0;
      linv_q      <= 1'b0;
      total_q     <= '0;
      fstat_q     <= cbd_pkg::ST_INCOMPLETE;
      max_q       <= cbd_pkg::MAX_BODY_RESET;
      out_valid_q <= 1'b0;
      status_q    <= cbd_pkg::ST_INCOMPLETE;
      pay_q       <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_wr) max_q <= pwdata;
      if (accept) begin
        phase_q     <= phase_d;
        clen_q      <= clen_d;
        dleft_q     <= dleft_d;
        linv_q      <= linv_d;
        total_q     <= total_d;
        fstat_q     <= fstat_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        pay_q       <= pay_d;
        count_q     <= total_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
